@@ src/nfa_pkg.sv @@
// ----------------------------------------------------------------------------
// nfa_pkg
// Shared widths, operation and status codes, and the lowest-free-bit
// encoder for the next-fit identifier allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package nfa_pkg;

  localparam int FUNC_W   = 2;
  localparam int ID_W     = 7;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 32;
  localparam int BIT_W    = 5;

  localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADID = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FREE  = 2'd3;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BIT_W-1:0]  bitpos_t;

  function automatic bitpos_t lowest_bit(input word_t v);
    bitpos_t r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/nfa_ram.sv @@
// ----------------------------------------------------------------------------
// nfa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic                                  rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ src/next_fit_id_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// next_fit_id_allocator_unit
// Next-fit identifier allocator. The used map lives in a RAM of 32-bit
// words; allocate scans words circularly from the search pointer.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_func, in_req_id
//   out      output     out_valid/out_stall out_status, out_id
//
// Free and query go from accept through S_FQ to S_DONE; rejected requests go
// straight to S_DONE. Allocate reads 1 to NUM_SLOTS/32 (rounded up) words in
// S_SCAN, one per cycle from the used-map RAM read port, then goes to S_DONE.
// One request is in flight at a time; out_stall holds the result register
// and the request waits in its final step until the register frees.
// Reset marks every map word invalid (reads as free) and zeroes the pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module next_fit_id_allocator_unit #(
  parameter int NUM_SLOTS = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [nfa_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [nfa_pkg::ID_W-1:0]      in_req_id,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [nfa_pkg::STATUS_W-1:0]  out_status,
  output logic      [nfa_pkg::ID_W-1:0]      out_id
);

  import nfa_pkg::*;

  localparam int WORDS    = (NUM_SLOTS + WORD_W - 1) / WORD_W;
  localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SW       = $clog2(NUM_SLOTS);
  localparam int LAST_REM = NUM_SLOTS - (WORDS - 1) * WORD_W;
  localparam word_t LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_REM);
  localparam logic [AW-1:0] LAST_W = AW'(WORDS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FQ   = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic [SW-1:0]       slot_r, slot_nxt;
  logic [SW-1:0]       ptr_r, ptr_nxt;
  logic [AW-1:0]       cur_w_r, cur_w_nxt;
  logic [AW-1:0]       start_w_r, start_w_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  word_t               lo_free_r, lo_free_nxt;
  word_t               start_eff_r, start_eff_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [WORDS-1:0]    vld_r, vld_nxt;
  logic                wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]       wr_addr_r, wr_addr_nxt;
  word_t               wr_data_r, wr_data_nxt;
  logic                ptr_upd_r, ptr_upd_nxt;
  logic [SW-1:0]       ptr_new_r, ptr_new_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ID_W-1:0]     res_id_r, res_id_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;

  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  word_t               rd_data;
  logic                wr_en;

  logic                in_range_c;
  logic [SW-1:0]       req_slot_c;
  logic [AW-1:0]       req_word_c;
  logic [AW-1:0]       ptr_word_c;
  logic [AW-1:0]       next_w_c;
  word_t               eff_c;
  word_t               wmask_c;
  word_t               free_c;
  word_t               hi_mask_c;
  word_t               hi_c;
  word_t               lo_c;
  word_t               cand_c;
  word_t               lo_sel_c;
  word_t               base_sel_c;
  word_t               sel_bits_c;
  word_t               sel_base_c;
  logic [AW-1:0]       sel_w_c;
  bitpos_t             bp_c;
  logic [SW-1:0]       fslot_c;
  logic [SW:0]         finc_c;
  logic [SW-1:0]       fnext_c;
  bitpos_t             slot_bit_c;
  logic                slot_used_c;

  nfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr_r),
    .wr_data (wr_data_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_range_c = ({{SW{1'b0}}, in_req_id} < (SW + ID_W)'(NUM_SLOTS));
  assign req_slot_c = SW'({{SW{1'b0}}, in_req_id});
  assign req_word_c = AW'(req_slot_c >> BIT_W);
  assign ptr_word_c = AW'(ptr_r >> BIT_W);
  assign next_w_c   = (cur_w_r == LAST_W) ? '0 : cur_w_r + 1'b1;

  assign eff_c      = rd_vld_r ? rd_data : '0;
  assign wmask_c    = (cur_w_r == LAST_W) ? LAST_MASK : '1;
  assign free_c     = ~eff_c & wmask_c;
  assign hi_mask_c  = {WORD_W{1'b1}} << BIT_W'(ptr_r);
  assign hi_c       = free_c & hi_mask_c;
  assign lo_c       = free_c & ~hi_mask_c;
  assign cand_c     = (cnt_r == '0) ? hi_c : free_c;
  assign lo_sel_c   = (cnt_r == '0) ? lo_c : lo_free_r;
  assign base_sel_c = (cnt_r == '0) ? eff_c : start_eff_r;

  assign sel_w_c    = (cand_c != '0) ? cur_w_r : start_w_r;
  assign sel_bits_c = (cand_c != '0) ? cand_c : lo_sel_c;
  assign sel_base_c = (cand_c != '0) ? eff_c : base_sel_c;
  assign bp_c       = lowest_bit(sel_bits_c);
  assign fslot_c    = SW'({sel_w_c, bp_c});
  assign finc_c     = {1'b0, fslot_c} + 1'b1;
  assign fnext_c    = (finc_c >= (SW + 1)'(NUM_SLOTS)) ? '0 : finc_c[SW-1:0];

  assign slot_bit_c  = BIT_W'(slot_r);
  assign slot_used_c = eff_c[slot_bit_c];

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    slot_nxt       = slot_r;
    ptr_nxt        = ptr_r;
    cur_w_nxt      = cur_w_r;
    start_w_nxt    = start_w_r;
    cnt_nxt        = cnt_r;
    lo_free_nxt    = lo_free_r;
    start_eff_nxt  = start_eff_r;
    vld_nxt        = vld_r;
    wr_pend_nxt    = wr_pend_r;
    wr_addr_nxt    = wr_addr_r;
    wr_data_nxt    = wr_data_r;
    ptr_upd_nxt    = ptr_upd_r;
    ptr_new_nxt    = ptr_new_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    rd_en          = 1'b0;
    rd_addr        = cur_w_r;
    wr_en          = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt       = in_func;
          slot_nxt       = req_slot_c;
          res_id_nxt     = in_req_id;
          res_status_nxt = ST_BADID;
          wr_pend_nxt    = 1'b0;
          ptr_upd_nxt    = 1'b0;
          state_nxt      = S_DONE;
          case (in_func)
            FN_ALLOC: begin
              rd_en       = 1'b1;
              rd_addr     = ptr_word_c;
              cur_w_nxt   = ptr_word_c;
              start_w_nxt = ptr_word_c;
              cnt_nxt     = '0;
              state_nxt   = S_SCAN;
            end
            FN_FREE: begin
              if (in_range_c) begin
                rd_en     = 1'b1;
                rd_addr   = req_word_c;
                state_nxt = S_FQ;
              end
            end
            FN_QUERY: begin
              if (in_range_c && (in_req_id != '0)) begin
                rd_en     = 1'b1;
                rd_addr   = req_word_c;
                state_nxt = S_FQ;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_FQ: begin
        res_status_nxt = slot_used_c ? ST_OK : ST_FREE;
        if ((func_r == FN_FREE) && slot_used_c) begin
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = AW'(slot_r >> BIT_W);
          wr_data_nxt = eff_c & ~(word_t'(1) << slot_bit_c);
        end
        state_nxt = S_DONE;
      end

      S_SCAN: begin
        if (cnt_r == '0) begin
          lo_free_nxt   = lo_c;
          start_eff_nxt = eff_c;
        end
        if ((cand_c != '0) || ((cnt_r == LAST_W) && (lo_sel_c != '0))) begin
          wr_pend_nxt    = 1'b1;
          wr_addr_nxt    = sel_w_c;
          wr_data_nxt    = sel_base_c | (word_t'(1) << bp_c);
          ptr_upd_nxt    = 1'b1;
          ptr_new_nxt    = fnext_c;
          res_status_nxt = ST_OK;
          res_id_nxt     = ID_W'(fslot_c);
          state_nxt      = S_DONE;
        end else if (cnt_r == LAST_W) begin
          res_status_nxt = ST_FULL;
          res_id_nxt     = '0;
          state_nxt      = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          cur_w_nxt = next_w_c;
          rd_en     = 1'b1;
          rd_addr   = next_w_c;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          if (wr_pend_r) begin
            wr_en              = 1'b1;
            vld_nxt[wr_addr_r] = 1'b1;
          end
          if (ptr_upd_r) begin
            ptr_nxt = ptr_new_r;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rd_vld_nxt = rd_en ? vld_r[rd_addr] : rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    slot_r       <= slot_nxt;
    cur_w_r      <= cur_w_nxt;
    start_w_r    <= start_w_nxt;
    cnt_r        <= cnt_nxt;
    lo_free_r    <= lo_free_nxt;
    start_eff_r  <= start_eff_nxt;
    rd_vld_r     <= rd_vld_nxt;
    wr_pend_r    <= wr_pend_nxt;
    wr_addr_r    <= wr_addr_nxt;
    wr_data_r    <= wr_data_nxt;
    ptr_upd_r    <= ptr_upd_nxt;
    ptr_new_r    <= ptr_new_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_id     = out_id_r;

endmodule

`default_nettype wire

@@ src/nfa_checker.sv @@
// ----------------------------------------------------------------------------
// nfa_checker
// Port-level checks for the next-fit identifier allocator, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nfa_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic [nfa_pkg::FUNC_W-1:0]    in_func,
  input wire logic [nfa_pkg::ID_W-1:0]      in_req_id,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [nfa_pkg::STATUS_W-1:0]  out_status,
  input wire logic [nfa_pkg::ID_W-1:0]      out_id
);

  import nfa_pkg::*;

  logic in_beat;
  assign in_beat = in_valid && !in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_id))
    else $error("stalled result beat changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> in_stall)
    else $error("second request taken while one is in flight");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat appeared without a request in flight");

  a_full_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_id == '0))
    else $error("full result carries a nonzero id");

  a_bad_func: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && !out_valid &&
      (in_func != FN_ALLOC) && (in_func != FN_FREE) && (in_func != FN_QUERY)
      |-> ##2 (out_valid && (out_status == ST_BADID) &&
               (out_id == $past(in_req_id, 2))))
    else $error("unknown operation not rejected");

endmodule

bind next_fit_id_allocator_unit nfa_checker u_nfa_checker (.*);

`default_nettype wire
